[design/sls_pkg.sv]
`default_nettype none
package sls_pkg;

	localparam int SourceBytesDef  = 65536;
	localparam int KeywordBytesDef = 8;
	localparam int KwCount         = 22;
	localparam int ResMax          = 3;

	typedef enum logic [5:0] {
		TK_EOF    = 6'd0,
		TK_ERROR  = 6'd1,
		TK_IDENT  = 6'd2,
		TK_NUMBER = 6'd3,
		TK_STRING = 6'd4,
		TK_DOT    = 6'd14,
		TK_SLASH  = 6'd17
	} tok_code_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_STR_OPEN = 3'd1,
		ERR_ESCAPE   = 3'd2,
		ERR_CMT_OPEN = 3'd3,
		ERR_CHAR     = 3'd4
	} err_code_t;

	localparam logic RK_TOKEN = 1'b0;
	localparam logic RK_BYTE  = 1'b1;

	typedef struct packed {
		logic        result_kind;
		logic [5:0]  token_kind;
		logic [2:0]  error_code;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic [15:0] line_number;
		logic [7:0]  byte_value;
		logic        last_of_run;
	} result_t;

	// keyword text, first character in the most significant used byte
	localparam logic [63:0] KW_TEXT [KwCount] = '{
		64'("and"), 64'("break"), 64'("catch"), 64'("class"), 64'("continue"),
		64'("else"), 64'("false"), 64'("for"), 64'("foreach"), 64'("function"),
		64'("if"), 64'("nil"), 64'("or"), 64'("print"), 64'("return"),
		64'("super"), 64'("this"), 64'("throw"), 64'("true"), 64'("try"),
		64'("var"), 64'("while")
	};
	localparam int KW_LEN [KwCount] = '{
		3, 5, 5, 5, 8, 4, 5, 3, 7, 8, 2, 3, 2, 5, 6, 5, 4, 5, 4, 3, 3, 5
	};
	localparam logic [5:0] KW_KIND_BASE = 6'd28;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"(": k = 6'd5;
			")": k = 6'd6;
			"{": k = 6'd7;
			"}": k = 6'd8;
			"[": k = 6'd9;
			"]": k = 6'd10;
			":": k = 6'd11;
			";": k = 6'd12;
			",": k = 6'd13;
			".": k = 6'd14;
			"-": k = 6'd15;
			"+": k = 6'd16;
			"%": k = 6'd18;
			"*": k = 6'd19;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op2_base(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"!": k = 6'd20;
			"=": k = 6'd22;
			"<": k = 6'd24;
			">": k = 6'd26;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

	// w holds buffer byte j at [8*j +: 8]; len is the identifier length
	function automatic logic [5:0] kw_kind(input logic [63:0] w, input logic [3:0] len);
		logic [5:0] k;
		logic       hit;
		int         lit;
		k = TK_IDENT;
		for (int i = 0; i < KwCount; i++) begin
			lit = KW_LEN[i];
			hit = (len == 4'(lit));
			for (int j = 0; j < 8; j++) begin
				if (j < lit) begin
					if (w[8*j +: 8] != 8'(KW_TEXT[i] >> (8 * (lit - 1 - j))))
						hit = 1'b0;
				end
			end
			if (hit)
				k = KW_KIND_BASE + 6'(i);
		end
		return k;
	endfunction

endpackage
`default_nettype wire

[design/sls_core.sv]
`default_nettype none
module sls_core #(
	parameter int SOURCE_BYTES  = 65536,
	parameter int KEYWORD_BYTES = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             in_byte,
	output sls_pkg::result_t [2:0]      res,
	output logic [1:0]                  res_n
);
	import sls_pkg::*;

	localparam int OFF_W = $clog2(SOURCE_BYTES);
	localparam int KWI_W = $clog2(KEYWORD_BYTES);
	localparam logic [OFF_W:0] SRC_SIZE = (OFF_W + 1)'(SOURCE_BYTES);
	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SOURCE_BYTES - 1);

	typedef enum logic [11:0] {
		PH_IDLE    = 12'b0000_0000_0001,
		PH_SLASH   = 12'b0000_0000_0010,
		PH_LINECMT = 12'b0000_0000_0100,
		PH_BLOCK   = 12'b0000_0000_1000,
		PH_STAR    = 12'b0000_0001_0000,
		PH_IDENT   = 12'b0000_0010_0000,
		PH_INT     = 12'b0000_0100_0000,
		PH_DOT     = 12'b0000_1000_0000,
		PH_FRAC    = 12'b0001_0000_0000,
		PH_OP2     = 12'b0010_0000_0000,
		PH_STR     = 12'b0100_0000_0000,
		PH_ESC     = 12'b1000_0000_0000
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [OFF_W-1:0]    ts_q, ts_d, off_q, off_d, swo_q, swo_d;
	logic [15:0]         line_q, line_d;
	logic [7:0]          kb_q [KEYWORD_BYTES];
	logic [7:0]          kb_d [KEYWORD_BYTES];
	logic [7:0]          pend_q, pend_d, quote_q, quote_d;

	function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] v);
		return (v == OFF_LAST) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [OFF_W-1:0] off_dec(input logic [OFF_W-1:0] v);
		return (v == '0) ? OFF_LAST : v - 1'b1;
	endfunction

	function automatic logic [OFF_W-1:0] off_dist(input logic [OFF_W-1:0] a,
			input logic [OFF_W-1:0] b);
		logic [OFF_W:0] d;
		d = {1'b0, b} - {1'b0, a};
		if (b < a)
			d = d + SRC_SIZE;
		return d[OFF_W-1:0];
	endfunction

	function automatic logic [15:0] to16(input logic [OFF_W-1:0] v);
		logic [OFF_W+15:0] t;
		t = {16'b0, v};
		return t[15:0];
	endfunction

	function automatic result_t mk(input logic rk, input logic [5:0] tk,
			input logic [2:0] err, input logic [OFF_W-1:0] off,
			input logic [OFF_W-1:0] len, input logic [7:0] bv, input logic [15:0] ln);
		result_t r;
		r.result_kind  = rk;
		r.token_kind   = tk;
		r.error_code   = err;
		r.start_offset = to16(off);
		r.token_length = to16(len);
		r.line_number  = ln;
		r.byte_value   = bv;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	logic [7:0]       b;
	logic [OFF_W-1:0] p, len, swo1;
	logic [63:0]      kw_word;
	logic [5:0]       id_kind;
	logic             rescan;
	logic [15:0]      line_up;
	result_t [2:0]    r;
	logic [1:0]       n;

	assign b       = in_byte;
	assign p       = off_q;
	assign line_up = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;

	always_comb begin
		for (int j = 0; j < 8; j++)
			kw_word[8*j +: 8] = kb_q[j];
	end

	// identifier ending at p
	always_comb begin
		len = off_dist(ts_q, p);
		if (len <= OFF_W'(8))
			id_kind = kw_kind(kw_word, len[3:0]);
		else
			id_kind = TK_IDENT;
	end

	always_comb begin
		phase_d = phase_q;
		ts_d    = ts_q;
		off_d   = off_q;
		swo_d   = swo_q;
		line_d  = line_q;
		kb_d    = kb_q;
		pend_d  = pend_q;
		quote_d = quote_q;
		r       = '0;
		n       = 2'd0;
		rescan  = 1'b0;
		swo1    = off_inc(swo_q);
		if (b == 8'd0) begin
			case (phase_q)
				PH_SLASH: begin
					r[n] = mk(RK_TOKEN, TK_SLASH, ERR_NONE, ts_q, OFF_W'(1), 8'd0, line_q);
					n = n + 2'd1;
				end
				PH_BLOCK, PH_STAR: begin
					r[n] = mk(RK_TOKEN, TK_ERROR, ERR_CMT_OPEN, ts_q, '0, 8'd0, line_q);
					n = n + 2'd1;
				end
				PH_IDENT: begin
					r[n] = mk(RK_TOKEN, id_kind, ERR_NONE, ts_q, len, 8'd0, line_q);
					n = n + 2'd1;
				end
				PH_INT, PH_FRAC: begin
					r[n] = mk(RK_TOKEN, TK_NUMBER, ERR_NONE, ts_q, len, 8'd0, line_q);
					n = n + 2'd1;
				end
				PH_DOT: begin
					r[n] = mk(RK_TOKEN, TK_NUMBER, ERR_NONE, ts_q,
						off_dist(ts_q, off_dec(p)), 8'd0, line_q);
					n = n + 2'd1;
					r[n] = mk(RK_TOKEN, TK_DOT, ERR_NONE, off_dec(p), OFF_W'(1), 8'd0, line_q);
					n = n + 2'd1;
				end
				PH_OP2: begin
					r[n] = mk(RK_TOKEN, op2_base(pend_q), ERR_NONE, ts_q, OFF_W'(1), 8'd0,
						line_q);
					n = n + 2'd1;
				end
				PH_STR, PH_ESC: begin
					r[n] = mk(RK_TOKEN, TK_ERROR, ERR_STR_OPEN, ts_q, '0, 8'd0, line_q);
					n = n + 2'd1;
				end
				default: ;
			endcase
			r[n] = mk(RK_TOKEN, TK_EOF, ERR_NONE, p, '0, 8'd0, line_q);
			n = n + 2'd1;
			phase_d = PH_IDLE;
			ts_d    = '0;
			off_d   = '0;
			swo_d   = '0;
			line_d  = 16'd1;
			pend_d  = 8'd0;
			quote_d = 8'd0;
		end else begin
			off_d = off_inc(p);
			case (phase_q)
				PH_SLASH: begin
					if (b == "/")
						phase_d = PH_LINECMT;
					else if (b == "*")
						phase_d = PH_STAR;
					else begin
						r[n] = mk(RK_TOKEN, TK_SLASH, ERR_NONE, ts_q, OFF_W'(1), 8'd0, line_q);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				PH_LINECMT: rescan = (b == "\n");
				PH_BLOCK: begin
					if (b == "*")
						phase_d = PH_STAR;
					else if (b == "\n")
						line_d = line_up;
				end
				PH_STAR: begin
					if (b == "/")
						phase_d = PH_IDLE;
					else begin
						if (b == "\n")
							line_d = line_up;
						phase_d = PH_BLOCK;
					end
				end
				PH_IDENT: begin
					if (is_alpha(b) || is_digit(b)) begin
						if (len < OFF_W'(KEYWORD_BYTES))
							kb_d[len[KWI_W-1:0]] = b;
					end else begin
						r[n] = mk(RK_TOKEN, id_kind, ERR_NONE, ts_q, len, 8'd0, line_q);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				PH_INT: begin
					if (b == ".")
						phase_d = PH_DOT;
					else if (!is_digit(b)) begin
						r[n] = mk(RK_TOKEN, TK_NUMBER, ERR_NONE, ts_q, len, 8'd0, line_q);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				PH_DOT: begin
					if (is_digit(b))
						phase_d = PH_FRAC;
					else begin
						r[n] = mk(RK_TOKEN, TK_NUMBER, ERR_NONE, ts_q,
							off_dist(ts_q, off_dec(p)), 8'd0, line_q);
						n = n + 2'd1;
						r[n] = mk(RK_TOKEN, TK_DOT, ERR_NONE, off_dec(p), OFF_W'(1), 8'd0,
							line_q);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				PH_FRAC: begin
					if (!is_digit(b)) begin
						r[n] = mk(RK_TOKEN, TK_NUMBER, ERR_NONE, ts_q, len, 8'd0, line_q);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				PH_OP2: begin
					if (b == "=") begin
						r[n] = mk(RK_TOKEN, op2_base(pend_q) + 6'd1, ERR_NONE, ts_q,
							OFF_W'(2), 8'd0, line_q);
						n = n + 2'd1;
						phase_d = PH_IDLE;
					end else begin
						r[n] = mk(RK_TOKEN, op2_base(pend_q), ERR_NONE, ts_q, OFF_W'(1),
							8'd0, line_q);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				PH_STR: begin
					if (b == quote_q) begin
						r[n] = mk(RK_BYTE, TK_STRING, ERR_NONE, swo_q, '0, b, line_q);
						n = n + 2'd1;
						r[n] = mk(RK_TOKEN, TK_STRING, ERR_NONE, ts_q, off_dist(ts_q, swo1),
							8'd0, line_q);
						n = n + 2'd1;
						swo_d   = swo1;
						phase_d = PH_IDLE;
					end else if (b == "\\")
						phase_d = PH_ESC;
					else begin
						r[n] = mk(RK_BYTE, TK_STRING, ERR_NONE, swo_q, '0, b, line_q);
						n = n + 2'd1;
						swo_d = swo1;
						if (b == "\n")
							line_d = line_up;
					end
				end
				PH_ESC: begin
					phase_d = PH_STR;
					case (b)
						"'", "\\", "\"": begin
							r[n] = mk(RK_BYTE, TK_STRING, ERR_NONE, swo_q, '0, b, line_q);
							n = n + 2'd1;
							swo_d = swo1;
						end
						"n": begin
							r[n] = mk(RK_BYTE, TK_STRING, ERR_NONE, swo_q, '0, 8'h0A, line_q);
							n = n + 2'd1;
							swo_d = swo1;
						end
						"r": begin
							r[n] = mk(RK_BYTE, TK_STRING, ERR_NONE, swo_q, '0, 8'h0D, line_q);
							n = n + 2'd1;
							swo_d = swo1;
						end
						"t": begin
							r[n] = mk(RK_BYTE, TK_STRING, ERR_NONE, swo_q, '0, 8'h09, line_q);
							n = n + 2'd1;
							swo_d = swo1;
						end
						default: begin
							r[n] = mk(RK_TOKEN, TK_ERROR, ERR_ESCAPE, ts_q, '0, 8'd0, line_q);
							n = n + 2'd1;
							phase_d = PH_IDLE;
						end
					endcase
				end
				default: rescan = 1'b1;
			endcase
			// scan the byte as the start of a new token
			if (rescan) begin
				phase_d = PH_IDLE;
				if (b == "\n")
					line_d = line_up;
				else if (b != " " && b != "\r" && b != "\t") begin
					ts_d = p;
					if (b == "/")
						phase_d = PH_SLASH;
					else if (is_alpha(b)) begin
						kb_d[0] = b;
						phase_d = PH_IDENT;
					end else if (is_digit(b))
						phase_d = PH_INT;
					else if (single_kind(b) != 6'd0) begin
						r[n] = mk(RK_TOKEN, single_kind(b), ERR_NONE, p, OFF_W'(1), 8'd0,
							line_q);
						n = n + 2'd1;
					end else if (op2_base(b) != 6'd0) begin
						pend_d  = b;
						phase_d = PH_OP2;
					end else if (b == "\"" || b == "'") begin
						quote_d = b;
						swo_d   = off_inc(p);
						phase_d = PH_STR;
					end else begin
						r[n] = mk(RK_TOKEN, TK_ERROR, ERR_CHAR, p, '0, 8'd0, line_q);
						n = n + 2'd1;
					end
				end
			end
		end
		if (n != 2'd0)
			r[n - 2'd1].last_of_run = 1'b1;
	end

	assign res   = r;
	assign res_n = step ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ts_q    <= '0;
			off_q   <= '0;
			swo_q   <= '0;
			line_q  <= 16'd1;
			pend_q  <= 8'd0;
			quote_q <= 8'd0;
			for (int i = 0; i < KEYWORD_BYTES; i++)
				kb_q[i] <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			ts_q    <= ts_d;
			off_q   <= off_d;
			swo_q   <= swo_d;
			line_q  <= line_d;
			pend_q  <= pend_d;
			quote_q <= quote_d;
			kb_q    <= kb_d;
		end
	end

endmodule
`default_nettype wire

[design/script_lexer_token_scanner.sv]
// channel  | handshake         | payload
// ---------+-------------------+---------------------------------------------
// in       | in_valid/in_stall | source_byte
// out      | out_valid/out_stall | result_kind token_kind error_code
//          |                   | start_offset token_length line_number
//          |                   | byte_value last_of_run
// One source byte per cycle enters the input register while in_stall is
// low; the scanner stage decodes it once the queue has three free entries
// and pushes zero to three results into an eight-entry result queue,
// drained one result per cycle while out_stall is low. Results are stored
// in the queue before they show on the outputs. Input stalls while the input
// register holds a byte and the queue has fewer than three free entries. Reset empties both.
`default_nettype none
module script_lexer_token_scanner #(
	parameter int SOURCE_BYTES  = sls_pkg::SourceBytesDef,
	parameter int KEYWORD_BYTES = sls_pkg::KeywordBytesDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  source_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic [5:0]       token_kind,
	output logic [2:0]       error_code,
	output logic [15:0]      start_offset,
	output logic [15:0]      token_length,
	output logic [15:0]      line_number,
	output logic [7:0]       byte_value,
	output logic             last_of_run
);
	import sls_pkg::*;

	localparam int QDEPTH = 8;
	localparam int QA_W   = $clog2(QDEPTH);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              go, take, pop;
	result_t [2:0]     res;
	logic [1:0]        res_n;
	result_t           q_mem [QDEPTH];
	logic [QA_W-1:0]   wr_q, rd_q;
	logic [QA_W:0]     cnt_q;

	assign go       = valid_s1 && (cnt_q <= (QA_W + 1)'(QDEPTH - ResMax));
	assign in_stall = valid_s1 && !go;
	assign take     = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (go)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			byte_s1 <= source_byte;
	end

	sls_core #(
		.SOURCE_BYTES  (SOURCE_BYTES),
		.KEYWORD_BYTES (KEYWORD_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go),
		.in_byte (byte_s1),
		.res     (res),
		.res_n   (res_n)
	);

	always_ff @(posedge clk) begin
		for (int k = 0; k < ResMax; k++) begin
			if (2'(k) < res_n)
				q_mem[wr_q + QA_W'(k)] <= res[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QA_W'(res_n);
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QA_W + 1)'(res_n) - (QA_W + 1)'(pop);
		end
	end

	assign out_valid    = (cnt_q != '0);
	assign result_kind  = q_mem[rd_q].result_kind;
	assign token_kind   = q_mem[rd_q].token_kind;
	assign error_code   = q_mem[rd_q].error_code;
	assign start_offset = q_mem[rd_q].start_offset;
	assign token_length = q_mem[rd_q].token_length;
	assign line_number  = q_mem[rd_q].line_number;
	assign byte_value   = q_mem[rd_q].byte_value;
	assign last_of_run  = q_mem[rd_q].last_of_run;

endmodule
`default_nettype wire

[design/sls_check.sv]
`default_nettype none
module sls_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        result_kind,
	input wire logic [5:0]  token_kind,
	input wire logic [2:0]  error_code,
	input wire logic [15:0] token_length,
	input wire logic [15:0] line_number,
	input wire logic [7:0]  byte_value,
	input wire logic        last_of_run
);
	import sls_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(byte_value))
		else $error("stalled result changed");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RK_TOKEN && (token_kind == TK_ERROR || token_kind == TK_EOF)
		|-> token_length == 16'd0)
		else $error("error or eof with nonzero length");

	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RK_BYTE |-> token_kind == TK_STRING
		&& error_code == ERR_NONE && token_length == 16'd0)
		else $error("bad string byte result");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RK_TOKEN && token_kind == TK_EOF |-> last_of_run)
		else $error("eof not last of run");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != 16'd0)
		else $error("line number zero");

endmodule

bind script_lexer_token_scanner sls_check u_sls_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_kind  (result_kind),
	.token_kind   (token_kind),
	.error_code   (error_code),
	.token_length (token_length),
	.line_number  (line_number),
	.byte_value   (byte_value),
	.last_of_run  (last_of_run)
);
`default_nettype wire
